/* design/pphd_pkg.sv */
`default_nettype none

package pphd_pkg;

   // Defaults for the top level parameters
   localparam int COORD_WIDTH_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   // Arctangent table, atan(2^-i) in Q.24 radians
   localparam int ATAN_LEN = 24;
   localparam int ATAN_W   = 24;
   localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2
   };

   localparam int PRE_SHIFT = 20;

   // Angles: Q.24 radians, wide enough for a full turn and the CORDIC sum
   localparam int ANGLE_W = 27;
   localparam logic [ANGLE_W-1:0] HALF_PI_Q24 = 27'd26353589;
   localparam logic [ANGLE_W-1:0] PI_Q24      = 27'd52707179;
   localparam logic [ANGLE_W-1:0] TWO_PI_Q24  = 27'd105414357;

   // Degree conversion: h * (180/pi in Q.24), then >> 41 with rounding
   localparam int RAD2DEG_W = 30;
   localparam logic [RAD2DEG_W-1:0] RAD2DEG_Q24 = 30'd961263669;
   localparam int PROD_W     = ANGLE_W + RAD2DEG_W;
   localparam int DEG_SHIFT  = 41;
   localparam int RAD_SHIFT  = 11;

   // Output formats
   localparam int HEAD_W = 16;
   localparam int DIST_W = 26;
   localparam logic [HEAD_W-1:0] FULL_RAD_Q13 = 16'd51472;
   localparam logic [HEAD_W-1:0] FULL_DEG_Q7  = 16'd46080;
   localparam logic [DIST_W-1:0] DIST_MAX     = 26'd47453133;

   // Distance path: magnitudes at or above 2^SAT_BIT saturate
   localparam int SAT_BIT    = 26;
   localparam int SQ_IN_W    = 26;
   localparam int RADICAND_W = 2 * SQ_IN_W + 1;
   localparam int SQRT_STEPS = (RADICAND_W + 1) / 2;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 3;

   // Result stream packing
   localparam int RSP_FIELDS_W = DIST_W + 4 * HEAD_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef struct packed {
      logic dx_neg;
      logic dy_neg;
      logic dx_zero;
      logic dy_zero;
      logic dist_sat;
   } flags_type;

   typedef struct packed {
      flags_type               flags;
      logic [RADICAND_W-1:0]   radicand;
   } cord_side_type;

   typedef struct packed {
      flags_type                  flags;
      logic signed [ANGLE_W-1:0]  angle;
   } root_side_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [HEAD_W-1:0] heading_rad;
      logic [HEAD_W-1:0] heading_deg;
      logic [HEAD_W-1:0] slope_rad;
      logic [HEAD_W-1:0] slope_deg;
      logic              zero_length;
   } result_type;

endpackage

`default_nettype wire

/* design/point_pair_heading_and_distance.sv */
`default_nettype none

// Point pair heading and distance. Each request transaction carries a start
// and an end point in signed Q16.8 screen coordinates (y grows downward); each
// response transaction carries the rounded Euclidean distance (Q18.8,
// saturating), the heading atan2(-dy,dx) in [0,2pi) as Q3.13 radians and
// Q9.7 degrees, a slope heading that reads a full turn along the positive x
// axis, and a zero-length flag in tuser for coinciding points (heading 0).
// The block takes one transaction per clock while the output buffer has room: a
// three-stage front end (differences, magnitudes, squares), CORDIC_STAGES vectoring
// stages, 27 square-root stages with one root bit each, and three finishing stages
// feed a two-entry output buffer. The pipeline holds while both output buffer
// entries are full.

module point_pair_heading_and_distance
   import pphd_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, end_x, end_y (COORD_WIDTH bits each), zero fill
   input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // distance[26], heading_rad[16], heading_deg[16], slope_rad[16],
   // slope_deg[16], zero fill
   output logic [RSP_TDATA_W-1:0]            rsp_tdata,
   // zero_length
   output logic                              rsp_tuser
);

   logic                          advance;
   logic signed [COORD_WIDTH-1:0] start_x, start_y, end_x, end_y;

   logic                 front_valid;
   logic [COORD_WIDTH:0] ax, ay;
   cord_side_type        front_side;

   logic                       cord_valid;
   logic signed [ANGLE_W-1:0]  cord_angle;
   cord_side_type              cord_side;
   root_side_type              root_side_in;

   logic                 sqrt_valid;
   logic [ROOT_W-1:0]    root;
   logic [REM_W-1:0]     remainder;
   root_side_type        sqrt_side;

   result_type           result;

   // Unpack the request, first field lowest
   assign start_x = $signed(req_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
   assign start_y = $signed(req_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
   assign end_x   = $signed(req_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
   assign end_y   = $signed(req_tdata[3*COORD_WIDTH +: COORD_WIDTH]);

   // Every stage advances together; a new request enters whenever they do
   assign req_tready = advance;

   pphd_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .start_x   (start_x),
      .start_y   (start_y),
      .end_x     (end_x),
      .end_y     (end_y),
      .out_valid (front_valid),
      .ax        (ax),
      .ay        (ay),
      .side      (front_side)
   );

   pphd_cordic #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .ax        (ax),
      .ay        (ay),
      .in_side   (front_side),
      .out_valid (cord_valid),
      .angle     (cord_angle),
      .out_side  (cord_side)
   );

   // The angle rides along the root stages as sideband
   assign root_side_in.flags = cord_side.flags;
   assign root_side_in.angle = cord_angle;

   pphd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (cord_valid),
      .radicand  (cord_side.radicand),
      .in_side   (root_side_in),
      .out_valid (sqrt_valid),
      .root      (root),
      .remainder (remainder),
      .out_side  (sqrt_side)
   );

   pphd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .root      (root),
      .remainder (remainder),
      .side      (sqrt_side),
      .out_ready (rsp_tready),
      .room      (advance),
      .out_valid (rsp_tvalid),
      .result    (result)
   );

   // Pack the response, first field lowest
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, result.slope_deg, result.slope_rad,
                       result.heading_deg, result.heading_rad, result.distance};
   assign rsp_tuser = result.zero_length;

endmodule

`default_nettype wire

/* design/pphd_front.sv */
`default_nettype none

module pphd_front
   import pphd_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] start_x,
   input  wire logic signed [COORD_WIDTH-1:0] start_y,
   input  wire logic signed [COORD_WIDTH-1:0] end_x,
   input  wire logic signed [COORD_WIDTH-1:0] end_y,
   output logic                               out_valid,
   output logic [COORD_WIDTH:0]               ax,
   output logic [COORD_WIDTH:0]               ay,
   output cord_side_type                      side
);

   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int EXT_W = (MAG_W > SAT_BIT + 1) ? MAG_W : SAT_BIT + 1;

   logic [2:0] valid_ff;

   // Stage 1: differences
   logic signed [MAG_W-1:0] dx_ff, dy_ff;
   logic signed [MAG_W-1:0] dx_in, dy_in;

   // Stage 2: magnitudes and flags
   logic [MAG_W-1:0]   ax2_ff, ay2_ff, ax2_in, ay2_in;
   logic [SQ_IN_W-1:0] sqx_in_ff, sqy_in_ff;
   logic [EXT_W-1:0]   ax_ext, ay_ext;
   flags_type          flags2_ff, flags2_in;

   // Stage 3: squares
   logic [MAG_W-1:0]       ax3_ff, ay3_ff;
   logic [2*SQ_IN_W-1:0]   sqx_ff, sqy_ff;
   flags_type              flags3_ff;

   assign dx_in = $signed({end_x[COORD_WIDTH-1], end_x})
                - $signed({start_x[COORD_WIDTH-1], start_x});
   assign dy_in = $signed({end_y[COORD_WIDTH-1], end_y})
                - $signed({start_y[COORD_WIDTH-1], start_y});

   always_comb begin
      flags2_in.dx_neg  = dx_ff[MAG_W-1];
      flags2_in.dy_neg  = dy_ff[MAG_W-1];
      flags2_in.dx_zero = (dx_ff == '0);
      flags2_in.dy_zero = (dy_ff == '0);
      ax2_in = dx_ff[MAG_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
      ay2_in = dy_ff[MAG_W-1] ? MAG_W'(-dy_ff) : MAG_W'(dy_ff);
      ax_ext = EXT_W'(ax2_in);
      ay_ext = EXT_W'(ay2_in);
      flags2_in.dist_sat = (ax_ext >= (EXT_W'(1) << SAT_BIT))
                        || (ay_ext >= (EXT_W'(1) << SAT_BIT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         ax2_ff    <= ax2_in;
         ay2_ff    <= ay2_in;
         sqx_in_ff <= ax_ext[SQ_IN_W-1:0];
         sqy_in_ff <= ay_ext[SQ_IN_W-1:0];
         flags2_ff <= flags2_in;
         ax3_ff    <= ax2_ff;
         ay3_ff    <= ay2_ff;
         sqx_ff    <= sqx_in_ff * sqx_in_ff;
         sqy_ff    <= sqy_in_ff * sqy_in_ff;
         flags3_ff <= flags2_ff;
      end
   end

   assign out_valid     = valid_ff[2];
   assign ax            = ax3_ff;
   assign ay            = ay3_ff;
   assign side.flags    = flags3_ff;
   assign side.radicand = RADICAND_W'(sqx_ff) + RADICAND_W'(sqy_ff);

endmodule

`default_nettype wire

/* design/pphd_cordic.sv */
`default_nettype none

module pphd_cordic
   import pphd_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic [COORD_WIDTH:0]      ax,
   input  wire logic [COORD_WIDTH:0]      ay,
   input  wire cord_side_type             in_side,
   output logic                           out_valid,
   output logic signed [ANGLE_W-1:0]      angle,
   output cord_side_type                  out_side
);

   // Magnitude after pre-shift and CORDIC gain, plus sign
   localparam int XW = COORD_WIDTH + PRE_SHIFT + 4;

   logic                      valid_ff [CORDIC_STAGES];
   logic signed [XW-1:0]      x_ff     [CORDIC_STAGES];
   logic signed [XW-1:0]      y_ff     [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0] z_ff     [CORDIC_STAGES];
   cord_side_type             side_ff  [CORDIC_STAGES];

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
      logic signed [XW-1:0]      x_src, y_src, x_in, y_in;
      logic signed [ANGLE_W-1:0] z_src, z_in, step;
      logic                      v_src;
      cord_side_type             s_src;

      if (g == 0) begin : g_first
         assign x_src = $signed(XW'({ax, {PRE_SHIFT{1'b0}}}));
         assign y_src = $signed(XW'({ay, {PRE_SHIFT{1'b0}}}));
         assign z_src = '0;
         assign v_src = in_valid;
         assign s_src = in_side;
      end else begin : g_next
         assign x_src = x_ff[g-1];
         assign y_src = y_ff[g-1];
         assign z_src = z_ff[g-1];
         assign v_src = valid_ff[g-1];
         assign s_src = side_ff[g-1];
      end

      assign step = $signed(ANGLE_W'(ATAN_TABLE[g]));

      // Rotate toward the x axis; the sign of y picks the direction
      always_comb begin
         if (!y_src[XW-1]) begin
            x_in = x_src + (y_src >>> g);
            y_in = y_src - (x_src >>> g);
            z_in = z_src + step;
         end else begin
            x_in = x_src - (y_src >>> g);
            y_in = y_src + (x_src >>> g);
            z_in = z_src - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[g]    <= x_in;
            y_ff[g]    <= y_in;
            z_ff[g]    <= z_in;
            side_ff[g] <= s_src;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STAGES-1];
   assign angle     = z_ff[CORDIC_STAGES-1];
   assign out_side  = side_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

/* design/pphd_sqrt.sv */
`default_nettype none

module pphd_sqrt
   import pphd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [RADICAND_W-1:0]   radicand,
   input  wire root_side_type           in_side,
   output logic                         out_valid,
   output logic [ROOT_W-1:0]            root,
   output logic [REM_W-1:0]             remainder,
   output root_side_type                out_side
);

   localparam int PAD_W = 2 * SQRT_STEPS;

   logic                valid_ff [SQRT_STEPS];
   logic [PAD_W-1:0]    rad_ff   [SQRT_STEPS];
   logic [REM_W-1:0]    rem_ff   [SQRT_STEPS];
   logic [ROOT_W-1:0]   q_ff     [SQRT_STEPS];
   root_side_type       side_ff  [SQRT_STEPS];

   // One root bit per stage: bring down two radicand bits, try 4q+1
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic [PAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src, shifted, trial;
      logic [ROOT_W-1:0] q_src;
      logic              v_src, fits;
      root_side_type     s_src;

      if (g == 0) begin : g_first
         assign rad_src = PAD_W'(radicand);
         assign rem_src = '0;
         assign q_src   = '0;
         assign v_src   = in_valid;
         assign s_src   = in_side;
      end else begin : g_next
         assign rad_src = rad_ff[g-1];
         assign rem_src = rem_ff[g-1];
         assign q_src   = q_ff[g-1];
         assign v_src   = valid_ff[g-1];
         assign s_src   = side_ff[g-1];
      end

      assign shifted = {rem_src[REM_W-3:0], rad_src[PAD_W-1 -: 2]};
      assign trial   = REM_W'({q_src, 2'b01});
      assign fits    = (shifted >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[g]  <= rad_src << 2;
            rem_ff[g]  <= fits ? (shifted - trial) : shifted;
            q_ff[g]    <= {q_src[ROOT_W-2:0], fits};
            side_ff[g] <= s_src;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign root      = q_ff[SQRT_STEPS-1];
   assign remainder = rem_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

`default_nettype wire

/* design/pphd_back.sv */
`default_nettype none

module pphd_back
   import pphd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic [ROOT_W-1:0]      root,
   input  wire logic [REM_W-1:0]       remainder,
   input  wire root_side_type          side,
   input  wire logic                   out_ready,
   output logic                        room,
   output logic                        out_valid,
   output result_type                  result
);

   // Stage 1: rounded root, first-quadrant angle
   logic                 b1_valid_ff;
   logic [ROOT_W-1:0]    b1_root_ff, b1_root_in;
   logic [ANGLE_W-1:0]   b1_theta_ff, b1_theta_in, clamped;
   flags_type            b1_flags_ff;

   // Stage 2: saturated distance, full-turn heading
   logic                 b2_valid_ff;
   logic [DIST_W-1:0]    b2_dist_ff, b2_dist_in;
   logic [ANGLE_W-1:0]   b2_h_ff, b2_h_in;
   flags_type            b2_flags_ff;

   // Stage 3: radian rounding, degree product
   logic                 b3_valid_ff;
   logic [DIST_W-1:0]    b3_dist_ff;
   logic [HEAD_W-1:0]    b3_rad_ff;
   logic [ANGLE_W-1:0]   rad_sum;
   logic [PROD_W-1:0]    b3_prod_ff;
   flags_type            b3_flags_ff;

   // Finish and output buffer
   logic [PROD_W-1:0]    deg_sum;
   logic [HEAD_W-1:0]    deg_raw, deg_sat, rad_sat;
   result_type           finished;
   logic                 push, pop;
   logic                 head_valid_ff, skid_valid_ff;
   result_type           head_ff, skid_ff;

   always_comb begin
      b1_root_in = root + ROOT_W'(remainder > REM_W'(root));
      if (side.angle[ANGLE_W-1]) begin
         clamped = '0;
      end else if (side.angle > $signed(HALF_PI_Q24)) begin
         clamped = HALF_PI_Q24;
      end else begin
         clamped = side.angle;
      end
      // Axis directions are exact
      if (side.flags.dy_zero) begin
         b1_theta_in = '0;
      end else if (side.flags.dx_zero) begin
         b1_theta_in = HALF_PI_Q24;
      end else begin
         b1_theta_in = clamped;
      end
   end

   always_comb begin
      if (b1_flags_ff.dist_sat || (b1_root_ff > ROOT_W'(DIST_MAX))) begin
         b2_dist_in = DIST_MAX;
      end else begin
         b2_dist_in = b1_root_ff[DIST_W-1:0];
      end
      // Quadrant fix-up; y grows downward
      if (!b1_flags_ff.dx_neg && (b1_flags_ff.dy_neg || b1_flags_ff.dy_zero)) begin
         b2_h_in = b1_theta_ff;
      end else if (b1_flags_ff.dx_neg && (b1_flags_ff.dy_neg || b1_flags_ff.dy_zero)) begin
         b2_h_in = PI_Q24 - b1_theta_ff;
      end else if (b1_flags_ff.dx_neg) begin
         b2_h_in = PI_Q24 + b1_theta_ff;
      end else begin
         b2_h_in = TWO_PI_Q24 - b1_theta_ff;
      end
   end

   assign rad_sum = b2_h_ff + (ANGLE_W'(1) << (RAD_SHIFT - 1));

   always_comb begin
      deg_sum  = b3_prod_ff + (PROD_W'(1) << (DEG_SHIFT - 1));
      deg_raw  = deg_sum[PROD_W-1:DEG_SHIFT];
      deg_sat  = (deg_raw > FULL_DEG_Q7) ? FULL_DEG_Q7 : deg_raw;
      rad_sat  = (b3_rad_ff > FULL_RAD_Q13) ? FULL_RAD_Q13 : b3_rad_ff;
      finished.distance    = b3_dist_ff;
      finished.zero_length = b3_flags_ff.dx_zero && b3_flags_ff.dy_zero;
      // Heading wraps a full turn to 0; coinciding points give 0
      if (finished.zero_length) begin
         finished.heading_rad = '0;
         finished.heading_deg = '0;
      end else begin
         finished.heading_rad = (rad_sat == FULL_RAD_Q13) ? '0 : rad_sat;
         finished.heading_deg = (deg_sat == FULL_DEG_Q7) ? '0 : deg_sat;
      end
      // Slope stays at a full turn along the positive x axis
      if (b3_flags_ff.dy_zero && !b3_flags_ff.dx_neg) begin
         finished.slope_rad = FULL_RAD_Q13;
         finished.slope_deg = FULL_DEG_Q7;
      end else begin
         finished.slope_rad = rad_sat;
         finished.slope_deg = deg_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_root_ff  <= b1_root_in;
         b1_theta_ff <= b1_theta_in;
         b1_flags_ff <= side.flags;
         b2_dist_ff  <= b2_dist_in;
         b2_h_ff     <= b2_h_in;
         b2_flags_ff <= b1_flags_ff;
         b3_dist_ff  <= b2_dist_ff;
         b3_rad_ff   <= rad_sum[ANGLE_W-1:RAD_SHIFT];
         b3_prod_ff  <= PROD_W'(b2_h_ff) * PROD_W'(RAD2DEG_Q24);
         b3_flags_ff <= b2_flags_ff;
      end
   end

   // Two-entry output buffer: the pipeline runs while the skid slot is free
   assign room = !skid_valid_ff;
   assign push = advance && b3_valid_ff;
   assign pop  = head_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!head_valid_ff || pop) begin
         head_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || pop) begin
         head_ff <= skid_valid_ff ? skid_ff : finished;
      end else if (push) begin
         skid_ff <= finished;
      end
   end

   assign out_valid = head_valid_ff;
   assign result    = head_ff;

endmodule

`default_nettype wire

/* design/pphd_checker.sv */
`default_nettype none

module pphd_checker
   import pphd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tuser
);

   logic [DIST_W-1:0] distance;
   logic [HEAD_W-1:0] heading_rad, heading_deg, slope_rad, slope_deg;

   assign distance    = rsp_tdata[DIST_W-1:0];
   assign heading_rad = rsp_tdata[DIST_W +: HEAD_W];
   assign heading_deg = rsp_tdata[DIST_W + HEAD_W +: HEAD_W];
   assign slope_rad   = rsp_tdata[DIST_W + 2*HEAD_W +: HEAD_W];
   assign slope_deg   = rsp_tdata[DIST_W + 3*HEAD_W +: HEAD_W];

   // Held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Coinciding points: zero distance, zero heading, slope at a full turn
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> distance == '0 && heading_rad == '0
         && heading_deg == '0 && slope_rad == FULL_RAD_Q13 && slope_deg == FULL_DEG_Q7)
      else $error("zero-length response has wrong fields");

   // Headings stay below a full turn, slopes reach it at most
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> heading_rad < FULL_RAD_Q13 && heading_deg < FULL_DEG_Q7
         && slope_rad <= FULL_RAD_Q13 && slope_deg <= FULL_DEG_Q7)
      else $error("heading out of range");

   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> distance <= DIST_MAX)
      else $error("distance above saturation value");

endmodule

bind point_pair_heading_and_distance pphd_checker u_pphd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
